// ----- rtl/blake2b_compress_macros.svh -----
// Assertion macros for the BLAKE2b compression engine.
// No dependencies; included by modules that check their own logic.
`ifndef BLAKE2B_COMPRESS_MACROS_SVH
`define BLAKE2B_COMPRESS_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define B2C_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition never holds outside reset.
`define B2C_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/b2c_pkg.sv -----
// Package for the BLAKE2b compression engine: commands, slots, IV and schedule tables.
// No dependencies.
`timescale 1ns / 1ps

package b2c_pkg;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_STORE    = 2'd1;
  localparam logic [1:0] CMD_COMPRESS = 2'd2;

  localparam logic [3:0] SLOT_CNT_LO = 4'd8;
  localparam logic [3:0] SLOT_CNT_HI = 4'd9;

  localparam logic [7:0] BLOCK_BYTES = 8'd128;
  localparam logic [3:0] LAST_ROUND  = 4'd11;
  localparam logic [3:0] SCHED_ROWS  = 4'd10;

  localparam logic [63:0] IV [0:7] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] SIGMA [0:9][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // Word indices a, b, c, d of the eight G applications of a round.
  localparam logic [3:0] GIDX [0:7][0:3] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}
  };

endpackage

// ----- rtl/blake2b_compress.sv -----
// BLAKE2b compression engine: chain and message memories, G unit, result sequencer.
// Depends on b2c_pkg and blake2b_compress_macros.svh.
`timescale 1ns / 1ps
// Usage:
// - Input channel (in_valid/in_stall) takes requests: cmd, slot, data_word,
//   byte_count, final_word0, final_word1. A request is taken when in_valid
//   is high and in_stall low.
// - Load and store requests give no result. Load slots
//   0-7 hit the chain memory, 8 and 9 the counter halves; other slots drop.
// - A compress request adds the saturated byte count to the 128-bit counter,
//   reads the chain memory into the working vector, runs 96 G steps on a
//   half-G unit (each step: one message read, then two half steps), then
//   reads, updates and writes back each chain word and sends the counter
//   halves. in_stall is high from the compress request until the last
//   result is registered.
// - Output channel (out_valid/out_stall) carries ten results: chain words
//   0-7, then counter low and high, last high on the tenth.
// - A stalled result holds in the output register; the sequencer waits.
// - Reset clears the counter and the chain valid bits (chain reads as zero
//   until loaded). Message words are undefined until stored.

`include "blake2b_compress_macros.svh"

module blake2b_compress (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  slot,
  input  logic [63:0] data_word,
  input  logic [7:0]  byte_count,
  input  logic [63:0] final_word0,
  input  logic [63:0] final_word1,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_slot,
  output logic [63:0] out_word,
  output logic        last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINRD = 3'd3;
  localparam logic [2:0] ST_FINWR = 3'd4;
  localparam logic [2:0] ST_OUTC  = 3'd5;

  logic [2:0]  state;
  logic [3:0]  idx;
  logic [3:0]  rnd;
  logic [2:0]  gsel;
  logic [1:0]  ph;
  logic [63:0] cnt_lo, cnt_hi;
  logic [63:0] v [16];

  // Memories: chain words with valid bits, message words with two read ports.
  logic [63:0] chain_mem [8];
  logic [7:0]  chain_ok;
  logic [63:0] chain_rd;
  logic        chain_rd_ok;
  logic [63:0] msg_mem [16];
  logic [63:0] msg_rd0, msg_rd1;

  logic        accept;
  logic        out_free;
  logic [3:0]  row;
  logic [3:0]  ma0, ma1;
  logic [3:0]  ia, ib, ic, id;
  logic [63:0] m, a1, d0, d1, c1, b0, b1;
  logic [63:0] chain_word, chain_new;
  logic [7:0]  nbytes;
  logic [64:0] lo_sum;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Rounds 10 and 11 reuse schedule rows 0 and 1.
  assign row = (rnd >= b2c_pkg::SCHED_ROWS) ? rnd - b2c_pkg::SCHED_ROWS : rnd;
  assign ma0 = b2c_pkg::SIGMA[row][{gsel, 1'b0}];
  assign ma1 = b2c_pkg::SIGMA[row][{gsel, 1'b1}];

  always_ff @(posedge clk) begin
    msg_rd0 <= msg_mem[ma0];
    msg_rd1 <= msg_mem[ma1];
    if (accept && cmd == b2c_pkg::CMD_STORE) begin
      msg_mem[slot] <= data_word;
    end
  end

  always_ff @(posedge clk) begin
    chain_rd    <= chain_mem[idx[2:0]];
    chain_rd_ok <= chain_ok[idx[2:0]];
    if (accept && cmd == b2c_pkg::CMD_LOAD && !slot[3]) begin
      chain_mem[slot[2:0]] <= data_word;
    end else if (state == ST_FINWR && out_free) begin
      chain_mem[idx[2:0]] <= chain_new;
    end
  end

  assign chain_word = chain_rd_ok ? chain_rd : 64'd0;
  assign chain_new  = chain_word ^ v[idx[2:0]] ^ v[{1'b1, idx[2:0]}];

  // Half G step: phase 1 uses the first message word, phase 2 the second.
  assign ia = b2c_pkg::GIDX[gsel][0];
  assign ib = b2c_pkg::GIDX[gsel][1];
  assign ic = b2c_pkg::GIDX[gsel][2];
  assign id = b2c_pkg::GIDX[gsel][3];
  assign m  = (ph == 2'd1) ? msg_rd0 : msg_rd1;
  assign a1 = v[ia] + v[ib] + m;
  assign d0 = v[id] ^ a1;
  assign d1 = (ph == 2'd1) ? {d0[31:0], d0[63:32]} : {d0[15:0], d0[63:16]};
  assign c1 = v[ic] + d1;
  assign b0 = v[ib] ^ c1;
  assign b1 = (ph == 2'd1) ? {b0[23:0], b0[63:24]} : {b0[62:0], b0[63]};

  assign nbytes = (byte_count > b2c_pkg::BLOCK_BYTES) ? b2c_pkg::BLOCK_BYTES : byte_count;
  assign lo_sum = {1'b0, cnt_lo} + {57'd0, nbytes};

  // Working vector: no reset, filled at the start of every compress.
  always_ff @(posedge clk) begin
    if (accept && cmd == b2c_pkg::CMD_COMPRESS) begin
      for (int i = 0; i < 4; i++) begin
        v[8 + i] <= b2c_pkg::IV[i];
      end
      v[12] <= b2c_pkg::IV[4] ^ lo_sum[63:0];
      v[13] <= b2c_pkg::IV[5] ^ (cnt_hi + {63'd0, lo_sum[64]});
      v[14] <= b2c_pkg::IV[6] ^ final_word0;
      v[15] <= b2c_pkg::IV[7] ^ final_word1;
    end else if (state == ST_INIT && idx != 4'd0) begin
      v[idx - 4'd1] <= chain_word;
    end else if (state == ST_ROUND && ph != 2'd0) begin
      v[ia] <= a1;
      v[id] <= d1;
      v[ic] <= c1;
      v[ib] <= b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= 4'd0;
      rnd       <= 4'd0;
      gsel      <= 3'd0;
      ph        <= 2'd0;
      cnt_lo    <= 64'd0;
      cnt_hi    <= 64'd0;
      chain_ok  <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      // Drop a result once the receiver takes it, unless the sequencer sends the next one.
      if (out_valid && !out_stall && state != ST_FINWR && state != ST_OUTC) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == b2c_pkg::CMD_LOAD) begin
              if (!slot[3]) begin
                chain_ok[slot[2:0]] <= 1'b1;
              end else if (slot == b2c_pkg::SLOT_CNT_LO) begin
                cnt_lo <= data_word;
              end else if (slot == b2c_pkg::SLOT_CNT_HI) begin
                cnt_hi <= data_word;
              end
            end else if (cmd == b2c_pkg::CMD_COMPRESS) begin
              cnt_lo <= lo_sum[63:0];
              cnt_hi <= cnt_hi + {63'd0, lo_sum[64]};
              idx    <= 4'd0;
              state  <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          if (idx == 4'd8) begin
            rnd   <= 4'd0;
            gsel  <= 3'd0;
            ph    <= 2'd0;
            state <= ST_ROUND;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        ST_ROUND: begin
          if (ph == 2'd2) begin
            ph   <= 2'd0;
            gsel <= gsel + 3'd1;
            if (gsel == 3'd7) begin
              if (rnd == b2c_pkg::LAST_ROUND) begin
                idx   <= 4'd0;
                state <= ST_FINRD;
              end else begin
                rnd <= rnd + 4'd1;
              end
            end
          end else begin
            ph <= ph + 2'd1;
          end
        end
        ST_FINRD: begin
          state <= ST_FINWR;
        end
        ST_FINWR: begin
          if (out_free) begin
            chain_ok[idx[2:0]] <= 1'b1;
            out_valid <= 1'b1;
            out_slot  <= idx;
            out_word  <= chain_new;
            last      <= 1'b0;
            idx       <= idx + 4'd1;
            state     <= (idx == 4'd7) ? ST_OUTC : ST_FINRD;
          end
        end
        ST_OUTC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_slot  <= idx;
            out_word  <= (idx == b2c_pkg::SLOT_CNT_LO) ? cnt_lo : cnt_hi;
            last      <= (idx == b2c_pkg::SLOT_CNT_HI);
            idx       <= idx + 4'd1;
            if (idx == b2c_pkg::SLOT_CNT_HI) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `B2C_ASSERT_IMP(a_last_slot, out_valid && last, out_slot == b2c_pkg::SLOT_CNT_HI, "last on wrong slot")
  `B2C_ASSERT_IMP(a_round_range, state == ST_ROUND, rnd <= b2c_pkg::LAST_ROUND && ph != 2'd3, "round counter out of range")
  `B2C_ASSERT_NEVER(a_out_when_busy, out_valid && !last && (state == ST_INIT || state == ST_ROUND), "result during rounds")
  `B2C_ASSERT_IMP(a_init_range, state == ST_INIT, idx <= 4'd8, "init index out of range")

endmodule
